### rtl/ssl_pkg.sv
// Shared constants and types for the shortest supersequence length block.
// No dependencies; every other file depends on this package.
package ssl_pkg;

	localparam int MAX_LEN_DEF = 1024;	// default string capacity
	localparam int CMD_W       = 2;
	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 12;	// result length field

	typedef enum logic [CMD_W-1:0] {
		CMD_FIRST  = 2'd0,	// byte of first string
		CMD_SECOND = 2'd1,	// byte of second string
		CMD_FINISH = 2'd2	// emit result, clear state
	} cmd_t;

	// control part of a token moving down the cell row
	typedef struct packed {
		logic valid;
		logic finish;	// 1: finish sweep, 0: second-string byte
	} tok_ctl_t;

endpackage

### rtl/ssl_if.sv
// Request and response channel interfaces for the supersequence length block.
// Depends on ssl_pkg for field widths.
interface ssl_req_if;
	logic                         valid;
	logic                         ready;
	logic [ssl_pkg::CMD_W-1:0]    command;
	logic [ssl_pkg::CHAR_W-1:0]   char_value;

	modport source(output valid, output command, output char_value, input ready);
	modport sink(input valid, input command, input char_value, output ready);
endinterface

interface ssl_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ssl_pkg::LEN_W-1:0]    supersequence_length;
	logic                         length_error;

	modport source(output valid, output supersequence_length, output length_error,
		input ready);
	modport sink(input valid, input supersequence_length, input length_error,
		output ready);
endinterface

### rtl/shortest_supersequence_length.sv
// Top level of the shortest common supersequence length block.
// Depends on ssl_pkg, ssl_if (ssl_req_if, ssl_rsp_if) and ssl_cell.
//
// Usage:
//   req carries command and char_value. First-string bytes (CMD_FIRST) are
//   written straight into cell number first_cnt_q, one per cycle while req.ready
//   is high. Second-string bytes (CMD_SECOND) enter the cell row as a token and
//   ripple one cell per cycle, so while req.ready is high a new one can follow
//   every cycle; each cell updates its LCS row entry as the token passes.
//   CMD_FINISH sends a finish token down the row. It collects the LCS value of
//   the last stored byte and clears every cell behind it. rsp.valid rises once
//   the finish token has left the row (MAX_LEN cells, one register each) and
//   reached the result register.
//   From a finish request until the response is taken, req.ready is low, so a
//   stalled receiver simply holds the result register and the block waits.
//   Requests that produce no result (string bytes, unused command) leave
//   req.ready high, so another request can follow.
//   Reset clears counters, error flag, cell valid bits and row values at once;
//   the first request is taken in the first cycle after reset.
//   A string longer than MAX_LEN bytes yields length_error = 1 and length 0.
module shortest_supersequence_length #(
	parameter int MAX_LEN = ssl_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ssl_req_if.sink     req,
	ssl_rsp_if.source   rsp
);
	import ssl_pkg::*;

	localparam int CNT_W = $clog2(MAX_LEN + 1);	// holds 0..MAX_LEN
	localparam int SUM_W = CNT_W + 1;

	logic [CNT_W-1:0]  first_cnt_q;
	logic [CNT_W-1:0]  second_cnt_q;
	logic              ovf_q;
	logic              busy_q;
	logic [SUM_W-1:0]  sum_q;
	logic              err_q;
	logic              rsp_valid_q;
	logic [LEN_W-1:0]  rsp_len_q;
	logic              rsp_err_q;

	logic              req_acc;
	logic              rsp_acc;
	logic              first_load;
	logic              first_ovf;
	logic              second_take;
	logic              second_ovf;
	logic              fin_take;
	logic [SUM_W-1:0]  total;

	// cell row links; index MAX_LEN is the end of the row
	tok_ctl_t          tok_w  [0:MAX_LEN];
	logic [CHAR_W-1:0] chr_w  [0:MAX_LEN];
	logic [CNT_W-1:0]  left_w [0:MAX_LEN];
	logic [CNT_W-1:0]  diag_w [0:MAX_LEN];

	assign req.ready = !busy_q;
	assign req_acc   = req.valid && !busy_q;
	assign rsp_acc   = rsp_valid_q && rsp.ready;

	// command decode
	always_comb begin
		first_load  = 1'b0;
		first_ovf   = 1'b0;
		second_take = 1'b0;
		second_ovf  = 1'b0;
		fin_take    = 1'b0;
		if (req_acc) begin
			unique case (req.command)
				CMD_FIRST: begin
					// bytes after the second string started are dropped
					if (second_cnt_q == '0) begin
						first_load = (first_cnt_q < CNT_W'(MAX_LEN));
						first_ovf  = !first_load;
					end
				end
				CMD_SECOND: begin
					second_take = (second_cnt_q < CNT_W'(MAX_LEN));
					second_ovf  = !second_take;
				end
				CMD_FINISH: begin
					fin_take = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// head of the row
	assign tok_w[0].valid = fin_take || (second_take && !ovf_q);
	assign tok_w[0].finish = fin_take;
	assign chr_w[0]  = req.char_value;
	assign left_w[0] = '0;
	assign diag_w[0] = '0;

	for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
		ssl_cell #(
			.VAL_W(CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (first_load && (first_cnt_q == CNT_W'(j))),
			.load_char(req.char_value),
			.tok_in   (tok_w[j]),
			.chr_in   (chr_w[j]),
			.left_in  (left_w[j]),
			.diag_in  (diag_w[j]),
			.tok_out  (tok_w[j+1]),
			.chr_out  (chr_w[j+1]),
			.left_out (left_w[j+1]),
			.diag_out (diag_w[j+1])
		);
	end

	// the finish token leaves the row carrying the LCS length
	assign total = sum_q - SUM_W'(left_w[MAX_LEN]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			ovf_q        <= 1'b0;
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (first_load) begin
				first_cnt_q <= first_cnt_q + CNT_W'(1);
			end
			if (second_take) begin
				second_cnt_q <= second_cnt_q + CNT_W'(1);
			end
			if (first_ovf || second_ovf) begin
				ovf_q <= 1'b1;
			end
			if (fin_take) begin
				first_cnt_q  <= '0;
				second_cnt_q <= '0;
				ovf_q        <= 1'b0;
				busy_q       <= 1'b1;
			end
			if (tok_w[MAX_LEN].valid && tok_w[MAX_LEN].finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_acc) begin
				rsp_valid_q <= 1'b0;
				busy_q      <= 1'b0;
			end
		end
	end

	// finish request payload and result register
	always_ff @(posedge clk) begin
		if (fin_take) begin
			sum_q <= SUM_W'(first_cnt_q) + SUM_W'(second_cnt_q);
			err_q <= ovf_q;
		end
		if (tok_w[MAX_LEN].valid && tok_w[MAX_LEN].finish) begin
			rsp_len_q <= err_q ? '0 : LEN_W'(total);
			rsp_err_q <= err_q;
		end
	end

	assign rsp.valid                = rsp_valid_q;
	assign rsp.supersequence_length = rsp_len_q;
	assign rsp.length_error         = rsp_err_q;

endmodule

### rtl/ssl_cell.sv
// One cell of the LCS row: holds one first-string byte and its row value.
// Depends on ssl_pkg (tok_ctl_t, CHAR_W).
module ssl_cell #(
	parameter int VAL_W = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [ssl_pkg::CHAR_W-1:0] load_char,
	input  ssl_pkg::tok_ctl_t          tok_in,
	input  logic [ssl_pkg::CHAR_W-1:0] chr_in,
	input  logic [VAL_W-1:0]           left_in,
	input  logic [VAL_W-1:0]           diag_in,
	output ssl_pkg::tok_ctl_t          tok_out,
	output logic [ssl_pkg::CHAR_W-1:0] chr_out,
	output logic [VAL_W-1:0]           left_out,
	output logic [VAL_W-1:0]           diag_out
);
	import ssl_pkg::*;

	logic [CHAR_W-1:0] a_q;
	logic              vld_q;
	logic [VAL_W-1:0]  row_q;
	tok_ctl_t          tok_q;
	logic [CHAR_W-1:0] chr_q;
	logic [VAL_W-1:0]  left_q;
	logic [VAL_W-1:0]  diag_q;
	logic [VAL_W-1:0]  cell_val;

	always_comb begin
		if (a_q == chr_in) begin
			cell_val = diag_in + VAL_W'(1);
		end else if (left_in > row_q) begin
			cell_val = left_in;
		end else begin
			cell_val = row_q;
		end
	end

	// control and row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			row_q <= '0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
			if (load) begin
				vld_q <= 1'b1;
			end
			if (tok_in.valid) begin
				if (tok_in.finish) begin
					vld_q <= 1'b0;
					row_q <= '0;
				end else if (vld_q) begin
					row_q <= cell_val;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= load_char;
		end
		chr_q <= chr_in;
		if (tok_in.finish) begin
			left_q <= vld_q ? row_q : left_in;
			diag_q <= left_in;
		end else if (vld_q) begin
			left_q <= cell_val;
			diag_q <= row_q;
		end else begin
			// past the end of the first string: carry the last value along
			left_q <= left_in;
			diag_q <= left_in;
		end
	end

	assign tok_out  = tok_q;
	assign chr_out  = chr_q;
	assign left_out = left_q;
	assign diag_out = diag_q;

endmodule
